/* src/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and types of the Bezier point evaluator: store depth,
// field widths and the item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W       = $clog2(MAX_POINTS);

    localparam int COORD_W     = 32;
    localparam int T_W         = 17;
    localparam logic [T_W-1:0] T_ONE = 17'd65536;

    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t         x;
        coord_t         y;
        coord_t         z;
        logic [T_W-1:0] t;
        logic           last;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_wr_t;

endpackage

/* src/bezier_point_evaluator.sv */
// A point that is not last is written into the point memory, while there is room, as the back end pops it.
// After the last point, each level of L points issues L memory reads, one a cycle, and
// then drains the four-stage interpolation pipeline before the next level.
// Throughput is set by the single read port of the point memory: one interpolation a cycle
// while a level issues; new points wait in the queue until the result is registered.
// Reset (aresetn, synchronous, active low) clears counts, flags, queue and handshakes.
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Evaluates one point on a Bezier curve of up to MAX_POINTS control points by
// de Casteljau's method, signed Q16.16 coordinates and unsigned Q1.16 t.
// ----------------------------------------------------------------------------
module bezier_point_evaluator
    import bpe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic [16:0]        s_curve_param,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_x,
    output logic signed [31:0] m_result_y,
    output logic signed [31:0] m_result_z,
    output logic               m_too_many_points
);

    q_wr_t q_wr;
    logic  q_full;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    bpe_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .s_curve_param (s_curve_param),
        .s_last_point  (s_last_point),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    bpe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bpe_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_x        (m_result_x),
        .m_result_y        (m_result_y),
        .m_result_z        (m_result_z),
        .m_too_many_points (m_too_many_points)
    );

endmodule

/* src/bpe_front.sv */
// ----------------------------------------------------------------------------
// bpe_front
// Input front end: takes control points, clamps t to 1.0 and pushes the
// packed item into the queue toward the evaluation back end.
// ----------------------------------------------------------------------------
module bpe_front
    import bpe_pkg::*;
(
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    input  logic signed [31:0]   s_point_z,
    input  logic [T_W-1:0]       s_curve_param,
    input  logic                 s_last_point,
    input  logic                 q_full,
    output q_wr_t                q_wr
);

    logic [T_W-1:0] t_clamped;

    // t above one behaves as exactly one
    assign t_clamped = (s_curve_param > T_ONE) ? T_ONE : s_curve_param;

    assign s_ready         = !q_full;
    assign q_wr.push       = s_valid && !q_full;
    assign q_wr.item.x     = s_point_x;
    assign q_wr.item.y     = s_point_y;
    assign q_wr.item.z     = s_point_z;
    assign q_wr.item.t     = t_clamped;
    assign q_wr.item.last  = s_last_point;

endmodule

/* src/bpe_queue.sv */
// ----------------------------------------------------------------------------
// bpe_queue
// Short queue between front end and back end so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module bpe_queue
    import bpe_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  q_wr_t  q_wr,
    output logic   q_full,
    output logic   q_valid,
    output item_t  q_item,
    input  logic   q_pop
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = q_wr.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_wr.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/bpe_back.sv */
// ----------------------------------------------------------------------------
// bpe_back
// Evaluation back end: keeps the control points in a point memory and runs
// the de Casteljau levels through a read / subtract / multiply / round
// pipeline, one interpolation per cycle while a level issues, then delivers the result.
// ----------------------------------------------------------------------------
module bpe_back
    import bpe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_x,
    output logic signed [31:0] m_result_y,
    output logic signed [31:0] m_result_z,
    output logic               m_too_many_points
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_FETCH,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef logic [2:0][COORD_W-1:0] point_t;

    // round half up, add to the start point, saturate to 32 bits
    function automatic logic [COORD_W-1:0] lerp_finish(
        input logic [COORD_W-1:0] a,
        input logic signed [50:0] p
    );
        logic signed [50:0] r;
        logic [35:0]        sum;
        r   = p + 51'sd32768;
        sum = {{4{a[31]}}, a} + {r[50], r[50:16]};
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
            return sum[31:0];
        end else if (sum[35]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    logic [T_W-1:0]     t_reg;
    logic [CNT_W-1:0]   lvl_reg;
    logic [IDX_W-1:0]   k_reg;
    logic               m_valid_reg;
    point_t             out_reg;
    logic               too_many_reg;
    point_t             res_reg;

    logic               rd_vld_reg;
    logic               rd_eval_reg;
    logic [IDX_W-1:0]   rd_k_reg;
    point_t             rdata_reg;

    point_t             a_reg;
    logic               s1_vld_reg;
    point_t             s1_a_reg;
    logic signed [32:0] s1_diff_reg [3];
    logic [IDX_W-1:0]   s1_idx_reg;

    logic               s2_vld_reg;
    point_t             s2_a_reg;
    logic signed [50:0] s2_prod_reg [3];
    logic [IDX_W-1:0]   s2_idx_reg;

    point_t             mem [MAX_POINTS];

    logic               pop;
    logic               room;
    logic [CNT_W-1:0]   n_after;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    point_t             mem_wd;
    point_t             wb_data;
    logic               pipe_empty;
    logic               out_free;

    assign pop        = q_valid && (state_reg == ST_LOAD);
    assign q_pop      = pop;
    assign room       = (cnt_reg < CNT_W'(MAX_POINTS));
    assign n_after    = room ? cnt_reg + 1'b1 : cnt_reg;
    assign rd_en      = (state_reg == ST_ISSUE) || (state_reg == ST_FETCH);
    assign rd_addr    = (state_reg == ST_ISSUE) ? k_reg : '0;
    assign pipe_empty = !rd_vld_reg && !s1_vld_reg && !s2_vld_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            wb_data[l] = lerp_finish(s2_a_reg[l], s2_prod_reg[l]);
        end
    end

    // load writes and write-back never overlap: write-back only runs while evaluating
    assign mem_we = (pop && room) || s2_vld_reg;
    assign mem_wa = s2_vld_reg ? s2_idx_reg : cnt_reg[IDX_W-1:0];
    assign mem_wd = s2_vld_reg ? wb_data : {q_item.z, q_item.y, q_item.x};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // interpolation datapath: a is the previous read, b the current one
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            a_reg <= rdata_reg;
        end
        s1_a_reg   <= a_reg;
        s1_idx_reg <= rd_k_reg - 1'b1;
        for (int l = 0; l < 3; l++) begin
            s1_diff_reg[l] <= {rdata_reg[l][31], rdata_reg[l]} - {a_reg[l][31], a_reg[l]};
            s2_prod_reg[l] <= s1_diff_reg[l] * $signed({1'b0, t_reg});
        end
        s2_a_reg   <= s1_a_reg;
        s2_idx_reg <= s1_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_eval_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            lvl_reg      <= '0;
            k_reg        <= '0;
        end else begin
            rd_vld_reg  <= rd_en;
            rd_eval_reg <= (state_reg == ST_ISSUE);
            rd_k_reg    <= k_reg;
            s1_vld_reg  <= rd_vld_reg && rd_eval_reg && (rd_k_reg != '0);
            s2_vld_reg  <= s1_vld_reg;
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (pop) begin
                        if (room) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (q_item.last) begin
                            t_reg <= q_item.t;
                            k_reg <= '0;
                            lvl_reg <= n_after;
                            if (ovf_reg || !room) begin
                                state_reg <= ST_FINISH;
                            end else if (n_after == CNT_W'(1)) begin
                                state_reg <= ST_FETCH;
                            end else begin
                                state_reg <= ST_ISSUE;
                            end
                        end
                    end
                end
                ST_ISSUE: begin
                    if (CNT_W'(k_reg) == lvl_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    // the next level reads what this one writes, so wait for write-back
                    if (pipe_empty) begin
                        k_reg <= '0;
                        if (lvl_reg == CNT_W'(2)) begin
                            state_reg <= ST_FETCH;
                        end else begin
                            lvl_reg   <= lvl_reg - 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (rd_vld_reg) begin
                        res_reg   <= rdata_reg;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        out_reg      <= ovf_reg ? '0 : res_reg;
                        too_many_reg <= ovf_reg;
                        cnt_reg      <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_x        = out_reg[0];
    assign m_result_y        = out_reg[1];
    assign m_result_z        = out_reg[2];
    assign m_too_many_points = too_many_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (cnt_reg == CNT_W'(MAX_POINTS)))
        else $error("overflow flagged with room left in store");

    a_wb_index: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg |-> (CNT_W'(s2_idx_reg) + 1'b1 < lvl_reg))
        else $error("write-back outside current level");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("interpolation pipeline busy while loading points");

endmodule
